FILE: rtl/core/pqms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority queue max select package
// Shared payload types, status codes and the entry ordering function.
// ----------------------------------------------------------------------------
package pqms_pkg;

  localparam int unsigned DefaultDepth = 16;

  localparam logic CmdInsert  = 1'b0;
  localparam logic CmdDequeue = 1'b1;

  typedef enum logic [1:0] {
    StInserted = 2'd0,
    StDequeued = 2'd1,
    StEmpty    = 2'd2,
    StFull     = 2'd3
  } status_e;

  typedef struct packed {
    logic               command;
    logic signed [15:0] in_value;
    logic [2:0]         in_priority;
  } pq_in_t;

  typedef struct packed {
    logic signed [15:0] out_value;
    logic [2:0]         out_priority;
    status_e            status;
    logic [4:0]         occupancy;
  } pq_out_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic [2:0]         prio;
  } entry_t;

  typedef struct packed {
    logic   found;
    entry_t entry;
  } cand_t;

  typedef struct packed {
    logic wr_en;
    logic shift_en;
  } cell_ctrl_t;

  // True when entry a is served before entry b (b is the earlier one on a tie).
  function automatic logic entry_better(entry_t a, entry_t b);
    logic result;
    result = (a.prio > b.prio) ||
             ((a.prio == b.prio) && ($signed(a.value) > $signed(b.value)));
    return result;
  endfunction

endpackage

FILE: rtl/core/priority_queue_max_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority queue max select
// Unsorted priority queue built from a row of storage cells.
// ----------------------------------------------------------------------------
// Input transactions arrive on in_valid_i / in_ready_o with in_data_i. An
// insert appends an entry after the stored ones; a dequeue removes the entry
// with the highest priority, then the larger value, then the earliest arrival,
// and closes the gap so arrival order is kept. Every input transaction gives
// exactly one output transaction on out_valid_o / out_ready_i with status and
// occupancy. An insert into a full queue or a dequeue from an empty one is
// reported and changes nothing.
// An insert, or a rejected command, writes its result into a holding register
// as it is accepted. A dequeue sends a scan token down the row of cells, one
// cell per cycle, and its result is captured as the token leaves the last
// cell. The Finish state then moves the result into the output register once
// that register is empty or being read. One transaction is in flight at a
// time; the next is taken once the previous result has entered the output
// register, so a stalled receiver holds the block after at most one more
// transaction. Reset empties the queue at once.
// ----------------------------------------------------------------------------
module priority_queue_max_select import pqms_pkg::*; #(
  parameter int unsigned Depth = DefaultDepth
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  pq_in_t  in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output pq_out_t out_data_o
);

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cell_ctrl_t      cell_ctrl;
  logic [CntW-1:0] count;
  logic [IdxW-1:0] sel_idx;
  entry_t          wr_entry;
  logic            scan_start;

  entry_t          entries  [Depth];
  entry_t          next_ents[Depth];
  logic            toks     [Depth];
  cand_t           cands    [Depth];
  logic [IdxW-1:0] cand_idxs[Depth];

  pqms_ctrl #(
    .Depth(Depth)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o),
    .cell_ctrl_o  (cell_ctrl),
    .count_o      (count),
    .sel_idx_o    (sel_idx),
    .wr_entry_o   (wr_entry),
    .scan_start_o (scan_start),
    .last_tok_i   (toks[Depth-1]),
    .last_cand_i  (cands[Depth-1]),
    .last_idx_i   (cand_idxs[Depth-1])
  );

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    if (i == Depth - 1) begin : g_last
      assign next_ents[i] = entries[i];
    end else begin : g_mid
      assign next_ents[i] = entries[i+1];
    end

    if (i == 0) begin : g_head
      pqms_cell #(
        .Depth(Depth),
        .Idx  (i)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (cell_ctrl),
        .count_i      (count),
        .sel_idx_i    (sel_idx),
        .wr_entry_i   (wr_entry),
        .next_entry_i (next_ents[i]),
        .entry_o      (entries[i]),
        .tok_i        (scan_start),
        .cand_i       ('0),
        .cand_idx_i   ('0),
        .tok_o        (toks[i]),
        .cand_o       (cands[i]),
        .cand_idx_o   (cand_idxs[i])
      );
    end else begin : g_body
      pqms_cell #(
        .Depth(Depth),
        .Idx  (i)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (cell_ctrl),
        .count_i      (count),
        .sel_idx_i    (sel_idx),
        .wr_entry_i   (wr_entry),
        .next_entry_i (next_ents[i]),
        .entry_o      (entries[i]),
        .tok_i        (toks[i-1]),
        .cand_i       (cands[i-1]),
        .cand_idx_i   (cand_idxs[i-1]),
        .tok_o        (toks[i]),
        .cand_o       (cands[i]),
        .cand_idx_o   (cand_idxs[i])
      );
    end
  end

endmodule

FILE: rtl/core/pqms_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority queue storage cell
// Holds one entry, takes part in the systolic best-entry scan and shifts
// down from its upper neighbor when its own or an earlier entry is removed.
// ----------------------------------------------------------------------------
module pqms_cell import pqms_pkg::*; #(
  parameter int unsigned Depth = DefaultDepth,
  parameter int unsigned Idx   = 0,
  localparam int unsigned IdxW = $clog2(Depth),
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_ctrl_t      ctrl_i,
  input  logic [CntW-1:0] count_i,
  input  logic [IdxW-1:0] sel_idx_i,
  input  entry_t          wr_entry_i,
  input  entry_t          next_entry_i,
  output entry_t          entry_o,
  input  logic            tok_i,
  input  cand_t           cand_i,
  input  logic [IdxW-1:0] cand_idx_i,
  output logic            tok_o,
  output cand_t           cand_o,
  output logic [IdxW-1:0] cand_idx_o
);

  entry_t          entry_q;
  logic            tok_q;
  cand_t           cand_q;
  logic [IdxW-1:0] cand_idx_q;
  logic            own_valid;
  logic            take_own;

  assign own_valid = CntW'(Idx) < count_i;
  assign take_own  = own_valid && (!cand_i.found || entry_better(entry_q, cand_i.entry));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en && (count_i == CntW'(Idx))) begin
      entry_q <= wr_entry_i;
    end else if (ctrl_i.shift_en && (sel_idx_i <= IdxW'(Idx)) &&
                 (CntW'(Idx + 1) < count_i)) begin
      entry_q <= next_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i) begin
      if (take_own) begin
        cand_q     <= '{found: 1'b1, entry: entry_q};
        cand_idx_q <= IdxW'(Idx);
      end else begin
        cand_q     <= cand_i;
        cand_idx_q <= cand_idx_i;
      end
    end
  end

  assign entry_o    = entry_q;
  assign tok_o      = tok_q;
  assign cand_o     = cand_q;
  assign cand_idx_o = cand_idx_q;

endmodule

FILE: rtl/core/pqms_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority queue controller
// Handshakes, entry count, scan launch, removal and the output register.
// ----------------------------------------------------------------------------
module pqms_ctrl import pqms_pkg::*; #(
  parameter int unsigned Depth = DefaultDepth,
  localparam int unsigned IdxW = $clog2(Depth),
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pq_in_t          in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pq_out_t         out_data_o,
  output cell_ctrl_t      cell_ctrl_o,
  output logic [CntW-1:0] count_o,
  output logic [IdxW-1:0] sel_idx_o,
  output entry_t          wr_entry_o,
  output logic            scan_start_o,
  input  logic            last_tok_i,
  input  cand_t           last_cand_i,
  input  logic [IdxW-1:0] last_idx_i
);

  typedef enum logic [1:0] {
    Idle,
    Scan,
    Finish
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] count_q;
  pq_out_t         res_q;
  pq_out_t         out_q;
  logic            out_valid_q;
  logic            accept;
  logic            is_full;
  logic            is_empty;

  assign in_ready_o = (state_q == Idle);
  assign accept     = in_valid_i && in_ready_o;
  assign is_full    = (count_q == CntW'(Depth));
  assign is_empty   = (count_q == '0);

  assign cell_ctrl_o.wr_en    = accept && (in_data_i.command == CmdInsert) && !is_full;
  assign cell_ctrl_o.shift_en = (state_q == Scan) && last_tok_i;
  assign scan_start_o         = accept && (in_data_i.command == CmdDequeue) && !is_empty;
  assign wr_entry_o           = '{value: in_data_i.in_value, prio: in_data_i.in_priority};
  assign sel_idx_o            = last_idx_i;
  assign count_o              = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= Idle;
      count_q     <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != Finish)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        Idle: begin
          if (accept) begin
            res_q.out_value    <= '0;
            res_q.out_priority <= '0;
            if (in_data_i.command == CmdInsert) begin
              if (is_full) begin
                res_q.status    <= StFull;
                res_q.occupancy <= 5'(count_q);
              end else begin
                res_q.status    <= StInserted;
                res_q.occupancy <= 5'(count_q + CntW'(1));
                count_q         <= count_q + CntW'(1);
              end
              state_q <= Finish;
            end else if (is_empty) begin
              res_q.status    <= StEmpty;
              res_q.occupancy <= '0;
              state_q         <= Finish;
            end else begin
              state_q <= Scan;
            end
          end
        end
        Scan: begin
          if (last_tok_i) begin
            res_q.out_value    <= last_cand_i.entry.value;
            res_q.out_priority <= last_cand_i.entry.prio;
            res_q.status       <= StDequeued;
            res_q.occupancy    <= 5'(count_q - CntW'(1));
            count_q            <= count_q - CntW'(1);
            state_q            <= Finish;
          end
        end
        Finish: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= Idle;
          end
        end
        default: begin
          state_q <= Idle;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  count_in_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("Entry count exceeds the queue depth.");

  insert_counts_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctrl_o.wr_en |=> count_q == $past(count_q) + CntW'(1))
    else $error("An accepted insert did not add one entry.");

  token_in_scan_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_tok_i |-> (state_q == Scan) && last_cand_i.found)
    else $error("Scan result arrived outside a scan or without a candidate.");

  scan_launch_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_start_o |=> (state_q == Scan) && (count_q != '0))
    else $error("A dequeue scan started without entries.");
`endif

endmodule

FILE: tb/sv/pqms_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority queue max select checker
// Watches both channels of the queue and keeps its own copy of the stored
// entries. Every accepted input transaction is turned into the result the
// queue must return, and every accepted output transaction is compared field
// by field with the oldest outstanding result.
// ----------------------------------------------------------------------------
module pqms_checker import pqms_pkg::*; #(
  parameter int unsigned Depth = DefaultDepth
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_ready_i,
  input  pq_in_t  in_data_i,
  input  logic    out_valid_i,
  input  logic    out_ready_i,
  input  pq_out_t out_data_i,
  output int      fail_count_o,
  output int      pending_o
);

  entry_t      stored [Depth];
  int unsigned fill;
  pq_out_t     queued_results [$];
  int          failures = 0;
  int          outstanding = 0;

  function automatic pq_out_t serve_command(pq_in_t item);
    pq_out_t     res;
    int unsigned best;
    res = '0;
    if (item.command == CmdInsert) begin
      if (fill >= Depth) begin
        res.status = StFull;
      end else begin
        stored[fill].value = item.in_value;
        stored[fill].prio  = item.in_priority;
        fill++;
        res.status = StInserted;
      end
    end else if (fill == 0) begin
      res.status = StEmpty;
    end else begin
      best = 0;
      for (int unsigned i = 1; i < fill; i++) begin
        if ((stored[i].prio > stored[best].prio) ||
            ((stored[i].prio == stored[best].prio) &&
             ($signed(stored[i].value) > $signed(stored[best].value)))) begin
          best = i;
        end
      end
      res.out_value    = stored[best].value;
      res.out_priority = stored[best].prio;
      for (int unsigned i = best; i + 1 < fill; i++) begin
        stored[i] = stored[i + 1];
      end
      fill--;
      res.status = StDequeued;
    end
    res.occupancy = 5'(fill);
    return res;
  endfunction

  task automatic check_result(pq_out_t got);
    pq_out_t want;
    if (queued_results.size() == 0) begin
      $error("result without a pending transaction: status %0d occupancy %0d",
             got.status, got.occupancy);
      failures++;
    end else begin
      want = queued_results.pop_front();
      if (got.out_value !== want.out_value) begin
        $error("out_value: expected %0d, actual %0d", want.out_value, got.out_value);
        failures++;
      end
      if (got.out_priority !== want.out_priority) begin
        $error("out_priority: expected %0d, actual %0d",
               want.out_priority, got.out_priority);
        failures++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        failures++;
      end
      if (got.occupancy !== want.occupancy) begin
        $error("occupancy: expected %0d, actual %0d", want.occupancy, got.occupancy);
        failures++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill = 0;
      queued_results.delete();
      outstanding = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        queued_results.push_back(serve_command(in_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        check_result(out_data_i);
      end
      outstanding = queued_results.size();
    end
  end

  assign fail_count_o = failures;
  assign pending_o    = outstanding;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority queue max select testbench
// Drives insert and dequeue transactions into the queue with random gaps and
// random output stalls. A directed opening covers the empty and full cases,
// extreme values and priority ties; a random part then picks filling, draining
// and mixed phases at random. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import pqms_pkg::*;

  localparam int unsigned Depth = DefaultDepth;

  typedef enum int {PhaseFill, PhaseDrain, PhaseMix} phase_e;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_ready;
  pq_in_t  in_data = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  pq_out_t out_data;
  int      fail_count;
  int      pending;
  bit      tx_quiet = 1'b0;
  bit      rx_quiet = 1'b0;
  int      sent = 0;

  priority_queue_max_select #(.Depth(Depth)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  pqms_checker #(.Depth(Depth)) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_item(logic cmd, logic [15:0] val, logic [2:0] prio);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data.command     <= cmd;
    in_data.in_value    <= val;
    in_data.in_priority <= prio;
    in_valid            <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_value(int mode);
    logic [15:0] v;
    case (mode)
      1: v = 16'($urandom_range(0, 4)) - 16'd2;
      2: begin
        case ($urandom_range(0, 3))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'h0000;
          default: v = 16'hFFFF;
        endcase
      end
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [2:0] pick_prio(int mode);
    return (mode == 1) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 7));
  endfunction

  initial begin : receiver
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        if ($urandom_range(0, 1) == 1) begin
          do @(posedge clk); while (!out_valid);
        end
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin : stimulus
    phase_e phase;
    int     len;
    int     vmode;
    int     pmode;
    logic   cmd;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(CmdDequeue, 16'hFFFF, 3'd7);
    send_item(CmdInsert, 16'h7FFF, 3'd7);
    send_item(CmdInsert, 16'h8000, 3'd7);
    send_item(CmdInsert, 16'hFFFF, 3'd3);
    send_item(CmdInsert, 16'h0001, 3'd3);
    send_item(CmdInsert, 16'hFFFF, 3'd3);
    send_item(CmdInsert, 16'h0000, 3'd0);
    for (int i = 0; i < 10; i++) begin
      send_item(CmdInsert, 16'(i * 3000 - 15000), 3'(i % 8));
    end
    send_item(CmdInsert, 16'h1234, 3'd7);
    repeat (6) send_item(CmdDequeue, 16'($urandom), 3'($urandom));
    drain_results();

    while (sent < 1224) begin
      phase    = phase_e'($urandom_range(0, 2));
      len      = $urandom_range(1, 20);
      vmode    = $urandom_range(0, 3);
      pmode    = $urandom_range(0, 1);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      repeat (len) begin
        case (phase)
          PhaseFill:  cmd = ($urandom_range(0, 7) != 0) ? CmdInsert : CmdDequeue;
          PhaseDrain: cmd = ($urandom_range(0, 7) != 0) ? CmdDequeue : CmdInsert;
          default:    cmd = 1'($urandom_range(0, 1));
        endcase
        send_item(cmd, pick_value(vmode), pick_prio(pmode));
      end
      if ($urandom_range(0, 7) == 0) begin
        drain_results();
      end
    end

    drain_results();
    repeat (Depth + 8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
